FILE: hdl/fip_pkg.sv
`default_nettype none

package fip_pkg;

	// default exponent width of the power port
	localparam int EXP_WIDTH_DEF = 32;

	// width of the mantissa product and the normalize register
	localparam int PW = 106;

	// binary64 constants
	localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DEF_NAN     = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

	// result status codes
	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_OVF = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOP,
		ST_MSETUP,
		ST_MPP,
		ST_NORM,
		ST_ROUND,
		ST_FINISH,
		ST_DSETUP,
		ST_DNORM,
		ST_DITER,
		ST_OUT
	} state_t;

	// where a finished rounding is written
	typedef enum logic [1:0] {
		DST_ACC,
		DST_BASE,
		DST_RES
	} dst_t;

	function automatic logic f_is_nan(input logic [63:0] x);
		return (&x[62:52]) && (|x[51:0]);
	endfunction

	function automatic logic f_is_inf(input logic [63:0] x);
		return (&x[62:52]) && !(|x[51:0]);
	endfunction

	function automatic logic f_is_zero(input logic [63:0] x);
		return !(|x[62:0]);
	endfunction

	function automatic logic [63:0] f_quiet(input logic [63:0] x);
		return x | QUIET_BIT;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/float_integer_power.sv
`default_nettype none

// Raises a binary64 base to a signed integer power by square-and-multiply from
// the low exponent bit, every product rounded to nearest-even, and a negative
// power finishing with a rounded reciprocal (zero to a negative power returns
// status 1 and a zero result). One request is worked at a time; in_ready is
// high only while the block is idle. All multiplies go through one shared
// 53x18-bit partial-product unit followed by a shared normalize and round
// stage. Each exponent bit but the top one costs one squaring, plus one
// multiply when the bit is set, each set up from the sequencer state ST_LOOP.
// The reciprocal uses a restoring divider at one quotient bit per cycle.
module float_integer_power
	import fip_pkg::*;
#(
	parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [63:0]          base_bits,
	input  wire logic [EXP_WIDTH-1:0] power,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [63:0]               result_bits,
	output logic                      status
);

	state_t state_q, state_d;
	dst_t   dst_q, dst_d;

	logic [63:0]          acc_q, acc_d;
	logic [63:0]          base_q, base_d;
	logic [EXP_WIDTH-1:0] mag_q, mag_d;
	logic                 flip_q, flip_d;
	logic                 neg_q, neg_d;
	logic                 acc_done_q, acc_done_d;
	logic                 status_q, status_d;

	logic [PW-1:0]        p_q, p_d;
	logic signed [13:0]   r_q, r_d;
	logic                 sgn_q, sgn_d;
	logic [52:0]          mul_a_q, mul_a_d;
	logic [53:0]          mul_b_q, mul_b_d;
	logic [5:0]           cnt_q, cnt_d;

	// shared datapath signals
	logic [63:0]        op_a;
	logic [70:0]        pp;
	logic [52:0]        rm;
	logic               rg, rs, rinc;
	logic [53:0]        mr;
	logic [52:0]        mant;
	logic signed [13:0] rr;
	logic [63:0]        rbits;
	logic               ge;
	logic [53:0]        rem_n;
	logic [63:0]        fin;
	logic               wb;
	logic [63:0]        wv;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign result_bits = acc_q;
	assign status      = status_q;

	// operand select, partial product, rounding, divider step and final sign flip
	always_comb begin
		op_a  = (dst_q == DST_BASE) ? base_q : acc_q;
		pp    = 71'(mul_a_q) * 71'(mul_b_q[53:36]);
		rm    = p_q[105:53];
		rg    = p_q[52];
		rs    = |p_q[51:0];
		rinc  = rg & (rs | rm[0]);
		mr    = {1'b0, rm} + 54'(rinc);
		if (mr[53]) begin
			mant = mr[53:1];
			rr   = r_q + 14'sd1;
		end else begin
			mant = mr[52:0];
			rr   = r_q;
		end
		if (rr >= 14'sd2047) begin
			rbits = {sgn_q, 11'h7FF, 52'b0};
		end else begin
			rbits = {sgn_q, (mant[52] ? rr[10:0] : 11'b0), mant[51:0]};
		end
		ge    = (mul_b_q >= {1'b0, mul_a_q});
		rem_n = ge ? (mul_b_q - {1'b0, mul_a_q}) : mul_b_q;
		fin   = flip_q ? {~acc_q[63], acc_q[62:0]} : acc_q;
	end

	// next state and sequencing
	always_comb begin
		state_d    = state_q;
		dst_d      = dst_q;
		acc_d      = acc_q;
		base_d     = base_q;
		mag_d      = mag_q;
		flip_d     = flip_q;
		neg_d      = neg_q;
		acc_done_d = acc_done_q;
		status_d   = status_q;
		p_d        = p_q;
		r_d        = r_q;
		sgn_d      = sgn_q;
		mul_a_d    = mul_a_q;
		mul_b_d    = mul_b_q;
		cnt_d      = cnt_q;
		wb         = 1'b0;
		wv         = rbits;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (base_bits[63] && !f_is_nan(base_bits) && !f_is_zero(base_bits)) begin
						base_d = {1'b0, base_bits[62:0]};
						flip_d = (power[EXP_WIDTH-1] ? (~power[0] ^ 1'b1) : power[0]);
					end else begin
						base_d = base_bits;
						flip_d = 1'b0;
					end
					neg_d      = power[EXP_WIDTH-1];
					mag_d      = power[EXP_WIDTH-1] ? (~power + 1'b1) : power;
					acc_d      = ONE_BITS;
					acc_done_d = 1'b0;
					status_d   = STAT_OK;
					state_d    = ST_LOOP;
				end
			end
			ST_LOOP: begin
				priority if (mag_q == '0) begin
					state_d = ST_FINISH;
				end else if (mag_q[0] && !acc_done_q) begin
					dst_d   = DST_ACC;
					state_d = ST_MSETUP;
				end else if (mag_q[EXP_WIDTH-1:1] == '0) begin
					mag_d = '0;
				end else begin
					dst_d   = DST_BASE;
					state_d = ST_MSETUP;
				end
			end
			ST_MSETUP: begin
				sgn_d = op_a[63] ^ base_q[63];
				priority if (f_is_nan(op_a)) begin
					wb = 1'b1;
					wv = f_quiet(op_a);
				end else if (f_is_nan(base_q)) begin
					wb = 1'b1;
					wv = f_quiet(base_q);
				end else if ((f_is_inf(op_a) && f_is_zero(base_q)) ||
						(f_is_zero(op_a) && f_is_inf(base_q))) begin
					wb = 1'b1;
					wv = DEF_NAN;
				end else if (f_is_inf(op_a) || f_is_inf(base_q)) begin
					wb = 1'b1;
					wv = {op_a[63] ^ base_q[63], 11'h7FF, 52'b0};
				end else if (f_is_zero(op_a) || f_is_zero(base_q)) begin
					wb = 1'b1;
					wv = {op_a[63] ^ base_q[63], 63'b0};
				end else begin
					mul_a_d = {(op_a[62:52] != 11'd0), op_a[51:0]};
					mul_b_d = {1'b0, (base_q[62:52] != 11'd0), base_q[51:0]};
					r_d     = 14'((op_a[62:52] == 11'd0) ? 14'sd1 : 14'(op_a[62:52]))
						+ 14'((base_q[62:52] == 11'd0) ? 14'sd1 : 14'(base_q[62:52]))
						- 14'sd1022;
					p_d     = '0;
					cnt_d   = '0;
					state_d = ST_MPP;
				end
			end
			ST_MPP: begin
				p_d     = {p_q[PW-19:0], 18'b0} + PW'(pp);
				mul_b_d = {mul_b_q[35:0], 18'b0};
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == 6'd2) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				priority if (r_q < 14'sd1) begin
					if (r_q < -14'sd108) begin
						p_d = {{(PW-1){1'b0}}, |p_q};
						r_d = 14'sd1;
					end else if (r_q <= -14'sd7) begin
						p_d = {8'b0, p_q[PW-1:9], p_q[8] | (|p_q[7:0])};
						r_d = r_q + 14'sd8;
					end else begin
						p_d = {1'b0, p_q[PW-1:2], p_q[1] | p_q[0]};
						r_d = r_q + 14'sd1;
					end
				end else if (!p_q[PW-1] && (r_q > 14'sd1)) begin
					if ((p_q[PW-1:PW-8] == 8'd0) && (r_q > 14'sd8)) begin
						p_d = {p_q[PW-9:0], 8'b0};
						r_d = r_q - 14'sd8;
					end else begin
						p_d = {p_q[PW-2:0], 1'b0};
						r_d = r_q - 14'sd1;
					end
				end else begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				wb = 1'b1;
				wv = rbits;
			end
			ST_FINISH: begin
				acc_d = fin;
				if (!neg_q) begin
					state_d = ST_OUT;
				end else if (f_is_zero(fin)) begin
					acc_d    = '0;
					status_d = STAT_OVF;
					state_d  = ST_OUT;
				end else begin
					dst_d   = DST_RES;
					state_d = ST_DSETUP;
				end
			end
			ST_DSETUP: begin
				sgn_d = acc_q[63];
				priority if (f_is_nan(acc_q)) begin
					wb = 1'b1;
					wv = f_quiet(acc_q);
				end else if (f_is_inf(acc_q)) begin
					wb = 1'b1;
					wv = {acc_q[63], 63'b0};
				end else begin
					mul_a_d = {(acc_q[62:52] != 11'd0), acc_q[51:0]};
					r_d     = (acc_q[62:52] == 11'd0) ? 14'sd1 : 14'(acc_q[62:52]);
					state_d = ST_DNORM;
				end
			end
			ST_DNORM: begin
				if (mul_a_q[52]) begin
					mul_b_d = 54'd1 << 52;
					p_d     = '0;
					cnt_d   = '0;
					state_d = ST_DITER;
				end else begin
					mul_a_d = {mul_a_q[51:0], 1'b0};
					r_d     = r_q - 14'sd1;
				end
			end
			ST_DITER: begin
				mul_b_d = {rem_n[52:0], 1'b0};
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == 6'd55) begin
					p_d     = {p_q[54:0], ge, 49'b0, (rem_n != '0)};
					r_d     = 14'sd2046 - r_q;
					state_d = ST_NORM;
				end else begin
					p_d = {p_q[PW-2:0], ge};
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// write back a finished product or reciprocal
		if (wb) begin
			unique case (dst_q)
				DST_ACC: begin
					acc_d      = wv;
					acc_done_d = 1'b1;
					state_d    = ST_LOOP;
				end
				DST_BASE: begin
					base_d     = wv;
					mag_d      = mag_q >> 1;
					acc_done_d = 1'b0;
					state_d    = ST_LOOP;
				end
				DST_RES: begin
					acc_d   = wv;
					state_d = ST_OUT;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dst_q      <= DST_ACC;
			acc_done_q <= 1'b0;
			status_q   <= STAT_OK;
			cnt_q      <= '0;
		end else begin
			state_q    <= state_d;
			dst_q      <= dst_d;
			acc_done_q <= acc_done_d;
			status_q   <= status_d;
			cnt_q      <= cnt_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_q   <= acc_d;
		base_q  <= base_d;
		mag_q   <= mag_d;
		flip_q  <= flip_d;
		neg_q   <= neg_d;
		p_q     <= p_d;
		r_q     <= r_d;
		sgn_q   <= sgn_d;
		mul_a_q <= mul_a_d;
		mul_b_q <= mul_b_d;
	end

endmodule

`default_nettype wire

FILE: hdl/fip_chk.sv
`default_nettype none

module fip_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] result_bits,
	input wire logic        status
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// one request at a time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready for a request while a result waits");

	// busy right after a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after a request");

	// overflow error carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_bits == 64'd0)
		else $error("error result is not zero");

	// idle again after the result is taken
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("not idle after result was taken");

endmodule

bind float_integer_power fip_chk u_fip_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_bits (result_bits),
	.status      (status)
);

`default_nettype wire

FILE: tb/sv/tb_float_integer_power.sv
`timescale 1ns / 1ps

module tb_float_integer_power;
	import fip_pkg::*;

	localparam int EW = EXP_WIDTH_DEF;
	localparam int N_RANDOM = 1580;

	typedef struct packed {
		logic [63:0] bits;
		logic        stat;
	} pow_result_t;

	typedef struct {
		logic [63:0]   base;
		logic [EW-1:0] pw;
		bit            fixed;
		pow_result_t   want;
	} pow_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [63:0] base_bits;
	logic [EW-1:0] power;
	logic out_valid;
	logic out_ready;
	logic [63:0] result_bits;
	logic status;

	pow_result_t pending_results[$];
	pow_result_t row_want;
	bit row_fixed;
	int n_accepted;
	int n_errors;

	float_integer_power #(.EXP_WIDTH(EW)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base_bits(base_bits),
		.power(power),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_bits(result_bits),
		.status(status)
	);

	// clock, 10 ns period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// square-and-multiply in binary64, each step rounded to nearest-even
	function automatic pow_result_t predict_power(logic [63:0] b, logic [EW-1:0] p);
		real x;
		real acc;
		logic [EW-1:0] mag;
		logic flip;
		logic neg;
		pow_result_t r;
		neg = p[EW-1];
		mag = neg ? (~p + 1'b1) : p;
		x = $bitstoreal(b);
		acc = 1.0;
		flip = 1'b0;
		if (x < 0.0) begin
			flip = mag[0];
			x = -x;
		end
		while (mag != '0) begin
			if (mag[0])
				acc = acc * x;
			x = x * x;
			mag = mag >> 1;
		end
		if (flip)
			acc = -acc;
		r.stat = STAT_OK;
		if (neg) begin
			if (acc == 0.0) begin
				r.bits = 64'd0;
				r.stat = STAT_OVF;
				return r;
			end
			acc = 1.0 / acc;
		end
		r.bits = $realtobits(acc);
		return r;
	endfunction

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45)
			return 0;
		else if (k < 92)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic logic [63:0] pick_base();
		int k;
		k = $urandom_range(0, 99);
		if (k < 20)
			return {$urandom, $urandom};
		else if (k < 85)
			// well-behaved magnitudes around one, random sign and mantissa
			return {1'($urandom), 11'($urandom_range(1013, 1033)), $urandom, 20'($urandom)};
		else begin
			case ($urandom_range(0, 5))
				0: return {1'($urandom), 63'd0};
				1: return {1'($urandom), 11'h7FF, 52'd0};
				2: return {1'($urandom), 11'h7FF, 20'($urandom) | 20'd1, $urandom};
				3: return {1'($urandom), 11'd0, 20'($urandom), $urandom};
				4: return {1'($urandom), 11'h3FF, 52'd0};
				default: return {1'($urandom), 11'h7FE, 20'($urandom), $urandom};
			endcase
		end
	endfunction

	function automatic logic [EW-1:0] pick_power();
		int k;
		logic [EW-1:0] m;
		k = $urandom_range(0, 99);
		if (k < 88) begin
			m = EW'($urandom_range(0, 70));
			return ($urandom_range(0, 1) != 0) ? (~m + 1'b1) : m;
		end else
			return EW'($urandom);
	endfunction

	// present one request and hold it until it is taken
	task automatic offer(logic [63:0] b, logic [EW-1:0] p, bit fx, pow_result_t w);
		int g;
		g = pick_gap();
		repeat (g) @(negedge clk);
		row_fixed = fx;
		row_want = w;
		base_bits = b;
		power = p;
		in_valid = 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
		in_valid = 1'b0;
		base_bits = {$urandom, $urandom};
		power = EW'($urandom);
	endtask

	// log each accepted request with its expected result
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			n_accepted <= n_accepted + 1;
			if (row_fixed)
				pending_results.push_back(row_want);
			else
				pending_results.push_back(predict_power(base_bits, power));
		end
	end

	// compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		pow_result_t w;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result %h status %0b", result_bits, status);
			end else begin
				w = pending_results.pop_front();
				if (w.bits !== result_bits || w.stat !== status) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: expected %h/%0b got %h/%0b",
							w.bits, w.stat, result_bits, status);
				end
			end
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		bit held;
		int g;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_accepted >= 100) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (1500) @(negedge clk);
			end
			g = pick_gap();
			if (g == 0 || $urandom_range(0, 3) == 0)
				out_ready = 1'b1;
			else begin
				out_ready = 1'b0;
				repeat (g - 1) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		pow_row_t rows[$];
		pow_result_t one_ok;
		pow_result_t zero_ok;
		pow_result_t ovf;
		pow_result_t dc;
		int waited;
		one_ok = '{bits: ONE_BITS, stat: STAT_OK};
		zero_ok = '{bits: 64'd0, stat: STAT_OK};
		ovf = '{bits: 64'd0, stat: STAT_OVF};
		dc = '{bits: 64'd0, stat: STAT_OK};
		n_accepted = 0;
		n_errors = 0;
		in_valid = 1'b0;
		base_bits = '0;
		power = '0;
		row_fixed = 1'b0;
		row_want = dc;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero exponent, any base gives one
		rows.push_back('{64'h4000_0000_0000_0000, 32'd0, 1, one_ok});
		rows.push_back('{64'h7FF8_0000_0000_0001, 32'd0, 1, one_ok});
		rows.push_back('{64'hFFF0_0000_0000_0000, 32'd0, 1, one_ok});
		rows.push_back('{64'h8000_0000_0000_0000, 32'd0, 1, one_ok});
		// zero to a negative power, both signs, an underflow to zero, and zero to a positive power
		rows.push_back('{64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1, ovf});
		rows.push_back('{64'h8000_0000_0000_0000, 32'hFFFF_FFFD, 1, ovf});
		rows.push_back('{64'h0000_0000_0000_0001, 32'h8000_0000, 1, ovf});
		rows.push_back('{64'h0000_0000_0000_0000, 32'd5, 1, zero_ok});
		// one to the most negative and most positive exponents
		rows.push_back('{ONE_BITS, 32'h8000_0000, 1, one_ok});
		rows.push_back('{ONE_BITS, 32'h7FFF_FFFF, 1, one_ok});
		// infinity reciprocal
		rows.push_back('{64'h7FF0_0000_0000_0000, 32'hFFFF_FFFF, 1, zero_ok});
		// predictor-checked rows: signs, nan bases, overflow, subnormals
		rows.push_back('{64'hBFF0_0000_0000_0000, 32'h7FFF_FFFF, 0, dc});
		rows.push_back('{64'hC000_0000_0000_0000, 32'd3, 0, dc});
		rows.push_back('{64'hC000_0000_0000_0000, 32'hFFFF_FFFD, 0, dc});
		rows.push_back('{64'h4000_0000_0000_0000, 32'h8000_0000, 0, dc});
		rows.push_back('{64'h8000_0000_0000_0000, 32'd3, 0, dc});
		rows.push_back('{64'hFFF8_0000_0000_0000, 32'd3, 0, dc});
		rows.push_back('{64'h7FF4_0000_0000_0000, 32'hFFFF_FFFE, 0, dc});
		rows.push_back('{64'h7FEF_FFFF_FFFF_FFFF, 32'd2, 0, dc});
		rows.push_back('{64'h7FEF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, dc});
		rows.push_back('{64'h0000_0000_0000_0001, 32'd1, 0, dc});
		rows.push_back('{64'h000F_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, dc});
		rows.push_back('{64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF, 0, dc});
		rows.push_back('{64'hBFEF_FFFF_FFFF_FFFF, 32'd37, 0, dc});
		rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF0, 0, dc});

		foreach (rows[i])
			offer(rows[i].base, rows[i].pw, rows[i].fixed, rows[i].want);

		for (int i = 0; i < N_RANDOM; i++) begin
			// one pause until the block has drained
			if (i == N_RANDOM / 2)
				wait (pending_results.size() == 0);
			offer(pick_base(), pick_power(), 0, dc);
		end

		wait (pending_results.size() == 0);
		waited = 0;
		while (waited < 50 && !out_valid) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0)
			n_errors++;
		if (n_errors == 0)
			$display("tb_float_integer_power: done, clean");
		else
			$display("tb_float_integer_power: done, errors");
		$finish;
	end

	// overall time limit
	initial begin
		#80ms;
		$display("tb_float_integer_power: done, errors");
		$finish;
	end

endmodule

FILE: float_integer_power.f
hdl/fip_pkg.sv
hdl/float_integer_power.sv
hdl/fip_chk.sv
tb/sv/tb_float_integer_power.sv
